// ===== src/itc_pkg.sv =====
// shared types and constants for the i2c timing word calculator
package itc_pkg;

  localparam int unsigned DW = 64;
  localparam int unsigned QW = 32;

  localparam logic [DW-1:0] NS_PER_S = 64'd1000000000;

  // fast mode limits
  localparam logic [DW-1:0] FM_SUM      = 64'd1900;
  localparam logic [DW-1:0] FM_SETUP    = 64'd400;
  localparam logic [DW-1:0] FM_TFMAX    = 64'd300;
  localparam logic [DW-1:0] FM_THIGH_US = 64'd600000000;
  localparam logic [DW-1:0] FM_TLOW_US  = 64'd1300000000;
  // fast mode plus limits
  localparam logic [DW-1:0] FP_SUM      = 64'd760;
  localparam logic [DW-1:0] FP_SETUP    = 64'd170;
  localparam logic [DW-1:0] FP_TFMAX    = 64'd120;
  localparam logic [DW-1:0] FP_THIGH_US = 64'd260000000;
  localparam logic [DW-1:0] FP_TLOW_US  = 64'd500000000;

  localparam logic [9:0] FMP_THRESH_KHZ = 10'd400;

  localparam logic [1:0] REG_RISE   = 2'd0;
  localparam logic [1:0] REG_FALL   = 2'd1;
  localparam logic [1:0] REG_FILTER = 2'd2;

  typedef enum logic [1:0] {
    ALU_MAC_ADD = 2'd0,
    ALU_MAC_SUB = 2'd1,
    ALU_DIV     = 2'd2
  } alu_op_e;

  typedef struct packed {
    logic           start;
    alu_op_e        op;
    logic [DW-1:0]  a;
    logic [DW-1:0]  b;
    logic [DW-1:0]  acc;
  } alu_req_t;

  typedef struct packed {
    logic           busy;
    logic           done;
    logic [DW-1:0]  result;
    logic           round_up;
  } alu_rsp_t;

endpackage

// ===== src/itc_alu.sv =====
// shared bit-serial multiply-accumulate and signed divide unit
module itc_alu (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  itc_pkg::alu_req_t req_i,
  output itc_pkg::alu_rsp_t rsp_o
);

  typedef enum logic [3:0] {
    A_IDLE = 4'b0001,
    A_MUL  = 4'b0010,
    A_DIV  = 4'b0100,
    A_FIX  = 4'b1000
  } alu_state_e;

  alu_state_e state_q, state_d;
  logic [itc_pkg::DW-1:0] x_q, x_d, a_q, a_d, b_q, b_d, res_q, res_d;
  logic [5:0] cnt_q, cnt_d;
  logic sub_q, sub_d, neg_q, neg_d, done_q, done_d, ru_q, ru_d;

  logic [itc_pkg::DW-1:0] opx, opy;
  logic                   cin;
  logic [itc_pkg::DW:0]   sum;

  always_comb begin
    if (state_q == A_DIV) begin
      opx = {x_q[itc_pkg::DW-2:0], a_q[itc_pkg::DW-1]};
      opy = ~b_q;
      cin = 1'b1;
    end else begin
      opx = x_q;
      opy = sub_q ? ~a_q : a_q;
      cin = sub_q;
    end
    sum = {1'b0, opx} + {1'b0, opy} + {{itc_pkg::DW{1'b0}}, cin};
  end

  always_comb begin
    state_d = state_q;
    x_d     = x_q;
    a_d     = a_q;
    b_d     = b_q;
    res_d   = res_q;
    cnt_d   = cnt_q;
    sub_d   = sub_q;
    neg_d   = neg_q;
    ru_d    = ru_q;
    done_d  = 1'b0;
    case (state_q)
      A_IDLE: begin
        if (req_i.start) begin
          cnt_d = '0;
          b_d   = req_i.b;
          if (req_i.op == itc_pkg::ALU_DIV) begin
            x_d     = '0;
            neg_d   = req_i.a[itc_pkg::DW-1];
            a_d     = req_i.a[itc_pkg::DW-1] ? (~req_i.a + 64'd1) : req_i.a;
            sub_d   = 1'b0;
            state_d = A_DIV;
          end else begin
            x_d     = req_i.acc;
            a_d     = req_i.a;
            sub_d   = (req_i.op == itc_pkg::ALU_MAC_SUB);
            state_d = A_MUL;
          end
        end
      end
      A_MUL: begin
        if (b_q[0]) x_d = sum[itc_pkg::DW-1:0];
        a_d   = {a_q[itc_pkg::DW-2:0], 1'b0};
        b_d   = {1'b0, b_q[itc_pkg::DW-1:1]};
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd31) begin
          res_d   = b_q[0] ? sum[itc_pkg::DW-1:0] : x_q;
          ru_d    = 1'b0;
          done_d  = 1'b1;
          state_d = A_IDLE;
        end
      end
      A_DIV: begin
        x_d   = sum[itc_pkg::DW] ? sum[itc_pkg::DW-1:0] : opx;
        a_d   = {a_q[itc_pkg::DW-2:0], sum[itc_pkg::DW]};
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd63) state_d = A_FIX;
      end
      A_FIX: begin
        res_d   = neg_q ? (~a_q + 64'd1) : a_q;
        ru_d    = !neg_q && (x_q != '0);
        done_d  = 1'b1;
        state_d = A_IDLE;
      end
      default: state_d = A_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    a_q   <= a_d;
    b_q   <= b_d;
    res_q <= res_d;
    sub_q <= sub_d;
    neg_q <= neg_d;
    ru_q  <= ru_d;
  end

  assign rsp_o.busy     = (state_q != A_IDLE);
  assign rsp_o.done     = done_q;
  assign rsp_o.result   = res_q;
  assign rsp_o.round_up = ru_q;

endmodule

// ===== src/i2c_timing_word_calculator.sv =====
// i2c timing word calculator top level with operation sequencer
// One beat in gives one beat out. All products and quotients run through one
// shared unit that resolves one bit per cycle. Setup of the common terms takes
// 13 multiply steps; each prescaler tried then costs 2 multiplies and 5 divides
// plus a fit check, and the prescalers are tried in turn until one fits or the
// last is reached. A zero clock or rate skips the arithmetic and goes straight
// to the output. The input is ready only while no item is in work; a finished
// result waits in the output register. Configuration writes are taken at any
// time but belong between items.
module i2c_timing_word_calculator #(
  parameter int unsigned PRESCALER_TRIES = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // clock_hz, bus_khz, filter_taps
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // timing_word, prescaler, scl_delay,
                                        // sda_delay, scl_high, scl_low
  output logic        m_axis_tuser_o,   // found
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ISSUE = 5'b00010,
    S_WAIT  = 5'b00100,
    S_CHECK = 5'b01000,
    S_EMIT  = 5'b10000
  } seq_state_e;

  typedef enum logic [4:0] {
    ST_D, ST_E, ST_TSR, ST_TSF, ST_NH0, ST_NH, ST_NL0, ST_NL, ST_R,
    ST_SN0, ST_SN1, ST_SN2, ST_SU,
    ST_UNIT, ST_Q, ST_DSCL, ST_DSDA, ST_DH, ST_DL, ST_DR
  } step_e;

  localparam logic [3:0] LAST_P = 4'(PRESCALER_TRIES - 1);

  seq_state_e state_q, state_d;
  step_e      step_q, step_d;
  logic [3:0] p_q, p_d;

  logic [7:0] rise_q, fall_q, filt_q;
  logic [29:0] f_q;
  logic [9:0]  k_q;
  logic [3:0]  taps_q;
  logic        fmp_q;

  logic [itc_pkg::DW-1:0] d_q, e_q, tsr_q, tsf_q, nh_q, nl_q, r_q, sn_q, su_q;
  logic [itc_pkg::DW-1:0] unit_q, q_q;
  logic signed [itc_pkg::QW-1:0] qs_q, qd_q, qh_q, ql_q, qr_q;
  logic ru_q;

  logic        found_q, found_d;
  logic [3:0]  rp_q, rp_d, rscl_q, rscl_d, rsda_q, rsda_d;
  logic [7:0]  rh_q, rh_d, rl_q, rl_d;

  logic        mvalid_q;
  logic [63:0] mdata_q;
  logic        muser_q;

  itc_pkg::alu_req_t req;
  itc_pkg::alu_rsp_t rsp;

  logic in_fire;
  logic [itc_pkg::DW-1:0] f64, c_sum, c_setup, c_tfmax, c_thigh, c_tlow;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  assign f64     = {34'd0, f_q};
  assign c_sum   = fmp_q ? itc_pkg::FP_SUM      : itc_pkg::FM_SUM;
  assign c_setup = fmp_q ? itc_pkg::FP_SETUP    : itc_pkg::FM_SETUP;
  assign c_tfmax = fmp_q ? itc_pkg::FP_TFMAX    : itc_pkg::FM_TFMAX;
  assign c_thigh = fmp_q ? itc_pkg::FP_THIGH_US : itc_pkg::FM_THIGH_US;
  assign c_tlow  = fmp_q ? itc_pkg::FP_TLOW_US  : itc_pkg::FM_TLOW_US;

  // operand selection per step
  always_comb begin
    req.start = (state_q == S_ISSUE);
    req.op    = itc_pkg::ALU_MAC_ADD;
    req.a     = '0;
    req.b     = '0;
    req.acc   = '0;
    case (step_q)
      ST_D:    begin req.a = c_sum; req.b = {54'd0, k_q}; end
      ST_E:    begin req.a = itc_pkg::NS_PER_S; req.b = {59'd0, {1'b0, taps_q} + 5'd2}; end
      ST_TSR:  begin
        req.a = f64; req.b = {55'd0, {1'b0, rise_q} + {1'b0, filt_q}}; req.acc = e_q;
      end
      ST_TSF:  begin
        req.a = f64; req.b = {55'd0, {1'b0, fall_q} + {1'b0, filt_q}}; req.acc = e_q;
      end
      ST_NH0:  begin req.a = c_thigh; req.b = f64; end
      ST_NH:   begin req.op = itc_pkg::ALU_MAC_SUB; req.a = tsr_q; req.b = d_q; req.acc = nh_q; end
      ST_NL0:  begin req.a = c_tlow; req.b = f64; end
      ST_NL:   begin req.op = itc_pkg::ALU_MAC_SUB; req.a = tsf_q; req.b = d_q; req.acc = nl_q; end
      ST_R:    begin req.a = nl_q; req.b = 64'd1; req.acc = nh_q; end
      ST_SN0:  begin req.a = f64; req.b = c_tfmax; end
      ST_SN1:  begin
        req.op = itc_pkg::ALU_MAC_SUB; req.a = f64; req.b = {56'd0, filt_q}; req.acc = sn_q;
      end
      ST_SN2:  begin
        req.op = itc_pkg::ALU_MAC_SUB; req.a = itc_pkg::NS_PER_S;
        req.b = {59'd0, {1'b0, taps_q} + 5'd3}; req.acc = sn_q;
      end
      ST_SU:   begin req.a = f64; req.b = c_setup; end
      ST_UNIT: begin req.a = itc_pkg::NS_PER_S; req.b = {59'd0, {1'b0, p_q} + 5'd1}; end
      ST_Q:    begin req.a = unit_q; req.b = d_q; end
      ST_DSCL: begin req.op = itc_pkg::ALU_DIV; req.a = su_q; req.b = unit_q; end
      ST_DSDA: begin req.op = itc_pkg::ALU_DIV; req.a = sn_q; req.b = unit_q; end
      ST_DH:   begin req.op = itc_pkg::ALU_DIV; req.a = nh_q; req.b = q_q; end
      ST_DL:   begin req.op = itc_pkg::ALU_DIV; req.a = nl_q; req.b = q_q; end
      ST_DR:   begin req.op = itc_pkg::ALU_DIV; req.a = r_q; req.b = q_q; end
      default: req.op = itc_pkg::ALU_MAC_ADD;
    endcase
  end

  itc_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  // fit check on the quotients
  logic signed [itc_pkg::QW-1:0] scl_raw, scl, sda, h0, l, need, h;
  logic sn_pos, fit;

  always_comb begin
    sn_pos  = !sn_q[itc_pkg::DW-1] && (sn_q != '0);
    scl_raw = qs_q - 32'sd1;
    scl     = scl_raw[itc_pkg::QW-1] ? '0 : scl_raw;
    sda     = sn_pos ? qd_q : '0;
    h0      = qh_q - 32'sd1;
    l       = ql_q - 32'sd1;
    need    = qr_q + $signed({31'd0, ru_q}) - l - 32'sd2;
    h       = (h0 < need) ? need : h0;
    fit     = (scl <= 32'sd15) && (sda <= 32'sd15) && (h >= 32'sd0) && (h <= 32'sd255)
              && (l >= 32'sd0) && (l <= 32'sd255);
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    p_d     = p_q;
    found_d = found_q;
    rp_d    = rp_q;
    rscl_d  = rscl_q;
    rsda_d  = rsda_q;
    rh_d    = rh_q;
    rl_d    = rl_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          found_d = 1'b0;
          rp_d    = '0;
          rscl_d  = '0;
          rsda_d  = '0;
          rh_d    = '0;
          rl_d    = '0;
          p_d     = '0;
          step_d  = ST_D;
          if (s_axis_tdata_i[29:0] == '0 || s_axis_tdata_i[39:30] == '0) begin
            state_d = S_EMIT;
          end else begin
            state_d = S_ISSUE;
          end
        end
      end
      S_ISSUE: state_d = S_WAIT;
      S_WAIT: begin
        if (rsp.done) begin
          if (step_q == ST_DR) begin
            state_d = S_CHECK;
          end else begin
            step_d  = step_e'(step_q + 5'd1);
            state_d = S_ISSUE;
          end
        end
      end
      S_CHECK: begin
        if (fit) begin
          found_d = 1'b1;
          rp_d    = p_q;
          rscl_d  = scl[3:0];
          rsda_d  = sda[3:0];
          rh_d    = h[7:0];
          rl_d    = l[7:0];
          state_d = S_EMIT;
        end else if (p_q == LAST_P) begin
          state_d = S_EMIT;
        end else begin
          p_d     = p_q + 4'd1;
          step_d  = ST_UNIT;
          state_d = S_ISSUE;
        end
      end
      S_EMIT: begin
        if (!mvalid_q || m_axis_tready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      step_q   <= ST_D;
      p_q      <= '0;
      mvalid_q <= 1'b0;
      rise_q   <= 8'd100;
      fall_q   <= 8'd10;
      filt_q   <= 8'd50;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      p_q     <= p_d;
      if (state_q == S_EMIT && (!mvalid_q || m_axis_tready_i)) begin
        mvalid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        mvalid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          itc_pkg::REG_RISE:   rise_q <= cfg_data_i;
          itc_pkg::REG_FALL:   fall_q <= cfg_data_i;
          itc_pkg::REG_FILTER: filt_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    found_q <= found_d;
    rp_q    <= rp_d;
    rscl_q  <= rscl_d;
    rsda_q  <= rsda_d;
    rh_q    <= rh_d;
    rl_q    <= rl_d;
    if (in_fire) begin
      f_q    <= s_axis_tdata_i[29:0];
      k_q    <= s_axis_tdata_i[39:30];
      taps_q <= s_axis_tdata_i[43:40];
      fmp_q  <= (s_axis_tdata_i[39:30] > itc_pkg::FMP_THRESH_KHZ);
    end
    if (state_q == S_WAIT && rsp.done) begin
      case (step_q)
        ST_D:    d_q    <= rsp.result;
        ST_E:    e_q    <= rsp.result;
        ST_TSR:  tsr_q  <= rsp.result;
        ST_TSF:  tsf_q  <= rsp.result;
        ST_NH0:  nh_q   <= rsp.result;
        ST_NH:   nh_q   <= rsp.result;
        ST_NL0:  nl_q   <= rsp.result;
        ST_NL:   nl_q   <= rsp.result;
        ST_R:    r_q    <= rsp.result;
        ST_SN0:  sn_q   <= rsp.result;
        ST_SN1:  sn_q   <= rsp.result;
        ST_SN2:  sn_q   <= rsp.result;
        ST_SU:   su_q   <= rsp.result;
        ST_UNIT: unit_q <= rsp.result;
        ST_Q:    q_q    <= rsp.result;
        ST_DSCL: qs_q   <= $signed(rsp.result[itc_pkg::QW-1:0]);
        ST_DSDA: qd_q   <= $signed(rsp.result[itc_pkg::QW-1:0]);
        ST_DH:   qh_q   <= $signed(rsp.result[itc_pkg::QW-1:0]);
        ST_DL:   ql_q   <= $signed(rsp.result[itc_pkg::QW-1:0]);
        ST_DR:   begin
          qr_q <= $signed(rsp.result[itc_pkg::QW-1:0]);
          ru_q <= rsp.round_up;
        end
        default: ;
      endcase
    end
    if (state_q == S_EMIT && (!mvalid_q || m_axis_tready_i)) begin
      mdata_q <= {4'd0, rl_q, rh_q, rsda_q, rscl_q, rp_q,
                  rp_q, 4'd0, rscl_q, rsda_q, rh_q, rl_q};
      muser_q <= found_q;
    end
  end

  assign m_axis_tvalid_o = mvalid_q;
  assign m_axis_tdata_o  = mdata_q;
  assign m_axis_tuser_o  = muser_q;

`ifndef SYNTHESIS
  a_nofit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mvalid_q && !muser_q |-> mdata_q == '0)
    else $error("not-found result carries nonzero fields");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.start |-> !rsp.busy)
    else $error("shared unit started while busy");
  a_busy_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.busy |-> state_q == S_WAIT)
    else $error("shared unit busy outside wait state");
  a_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.done |-> state_q == S_WAIT)
    else $error("unit result returned outside wait state");
`endif

endmodule
